// ===== src/jse_pkg.sv =====
// Shared types, byte constants and a hex-digit helper for the JSON string escaper.
package jse_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_OUT     = 16;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;

    localparam logic [7:0] REP_BYTE0 = 8'hEF;
    localparam logic [7:0] REP_BYTE1 = 8'hBF;
    localparam logic [7:0] REP_BYTE2 = 8'hBD;

    localparam logic [7:0] LEAD2_LO  = 8'hC2;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_HI  = 8'hF4;
    localparam logic [7:0] LEAD_SURR = 8'hED;
    localparam logic [7:0] CONT_A0   = 8'hA0;
    localparam logic [7:0] CONT_90   = 8'h90;
    localparam logic [7:0] CTRL_TOP  = 8'h20;
    localparam logic [7:0] ASCII_TOP = 8'h80;

    // One raw text byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       text_end;
    } jse_in_t;

    // One output byte
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       closing_quote;
    } jse_out_t;

    // Expansion job for one item: open quote, replacements, character bytes,
    // replacements for a truncated sequence, closing quote
    typedef struct packed {
        logic            open_quote;
        logic [2:0]      rep_a;
        logic [2:0]      char_len;
        logic [5:0][7:0] char_bytes;
        logic [1:0]      rep_e;
        logic            close_quote;
        logic [4:0]      out_count;
    } jse_job_t;

    // Lowercase hex digit
    function automatic logic [7:0] nib_to_hex(input logic [3:0] nib);
        logic [7:0] res;
        if (nib < 4'd10)
        begin
            res = 8'h30 + {4'b0, nib};
        end
        else
        begin
            res = 8'h57 + {4'b0, nib};
        end
        return res;
    endfunction

endpackage

// ===== src/json_string_escape_utf8_sanitize.sv =====
// Top level of the JSON string escaper with UTF-8 cleanup.
// One raw byte per item comes in through push/full; quoted, escaped bytes leave one
// per cycle through empty/pop while pop is high. The front end takes an item every
// cycle while the job queue (QUEUE_DEPTH entries, default 4) has room, and turns it
// into a job of 0 to 16 output bytes. The back end presents one job's output bytes
// in turn; plain text runs at one item per cycle while pop is high. Bytes of a
// multi-byte UTF-8 character are held and are not output until the character
// completes. At most 16 bytes leave for any one item.
module json_string_escape_utf8_sanitize
    import jse_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  jse_in_t  item,
    input  logic     push,
    output logic     full,
    output jse_out_t result,
    output logic     empty,
    input  logic     pop
);

    jse_job_t front_job, head_job;
    logic     front_valid, job_done, accept;

    assign accept = push && !full;

    jse_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .accept    (accept),
        .job       (front_job),
        .job_valid (front_valid)
    );

    jse_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (front_valid),
        .wr_job (front_job),
        .full   (full),
        .rd_en  (job_done),
        .rd_job (head_job),
        .empty  (empty)
    );

    jse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (head_job),
        .job_empty (empty),
        .job_done  (job_done),
        .pop       (pop),
        .result    (result)
    );

endmodule

// ===== src/jse_front.sv =====
// Front end: tracks UTF-8 sequence state and turns each item into an expansion job.
module jse_front
    import jse_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  jse_in_t  item,
    input  logic     accept,
    output jse_job_t job,
    output logic     job_valid
);

    logic [2:0][7:0] held_reg, held_next;
    logic [1:0]      held_count_reg, held_count_next;
    logic [2:0]      seq_len_reg, seq_len_next;
    logic            inside_reg, inside_next;

    logic [7:0] b;
    logic       cont_ok;
    logic [1:0] store_idx;
    logic [5:0] total;

    assign b = item.data_byte;

    // Check whether the byte may continue the held sequence
    always_comb
    begin
        cont_ok = (b[7:6] == 2'b10);
        if (held_count_reg == 2'd1)
        begin
            if ((held_reg[0] == LEAD3_LO && b < CONT_A0) ||
                (held_reg[0] == LEAD_SURR && b >= CONT_A0) ||
                (held_reg[0] == LEAD4_LO && b < CONT_90) ||
                (held_reg[0] == LEAD4_HI && b >= CONT_90))
            begin
                cont_ok = 1'b0;
            end
        end
    end

    assign store_idx = (held_count_reg == 2'd3) ? 2'd0 : held_count_reg;

    // Build the job and the next sequence state
    always_comb
    begin
        logic start;
        held_next       = held_reg;
        held_count_next = held_count_reg;
        seq_len_next    = seq_len_reg;
        inside_next     = inside_reg;
        job             = '0;
        start           = 1'b0;

        if (accept && (item.byte_present || item.text_end))
        begin
            job.open_quote = !inside_reg;
            inside_next    = 1'b1;
            if (item.byte_present)
            begin
                if (held_count_reg == 2'd0 || seq_len_reg < 3'd2)
                begin
                    start = 1'b1;
                end
                else if (cont_ok)
                begin
                    if ({1'b0, held_count_reg} + 3'd1 >= seq_len_reg)
                    begin
                        // pass the completed sequence through
                        for (int i = 0; i < 3; i++)
                        begin
                            if (i < int'(held_count_reg))
                            begin
                                job.char_bytes[3'(i)] = held_reg[2'(i)];
                            end
                        end
                        job.char_bytes[{1'b0, held_count_reg}] = b;
                        job.char_len    = {1'b0, held_count_reg} + 3'd1;
                        held_count_next = 2'd0;
                        seq_len_next    = 3'd0;
                    end
                    else
                    begin
                        held_next[store_idx] = b;
                        held_count_next      = held_count_reg + 2'd1;
                    end
                end
                else
                begin
                    // drop the broken sequence, then restart on this byte
                    job.rep_a = {1'b0, held_count_reg};
                    start     = 1'b1;
                end

                if (start)
                begin
                    held_count_next = 2'd0;
                    seq_len_next    = 3'd0;
                    if (b < ASCII_TOP)
                    begin
                        job.char_len = 3'd2;
                        job.char_bytes[0] = CH_BSLASH;
                        case (b)
                            CH_QUOTE:  job.char_bytes[1] = CH_QUOTE;
                            CH_BSLASH: job.char_bytes[1] = CH_BSLASH;
                            8'h0A:     job.char_bytes[1] = CH_N;
                            8'h0D:     job.char_bytes[1] = CH_R;
                            8'h09:     job.char_bytes[1] = CH_T;
                            8'h08:     job.char_bytes[1] = CH_B;
                            8'h0C:     job.char_bytes[1] = CH_F;
                            default:
                            begin
                                if (b < CTRL_TOP)
                                begin
                                    job.char_len      = 3'd6;
                                    job.char_bytes[1] = CH_U;
                                    job.char_bytes[2] = CH_ZERO;
                                    job.char_bytes[3] = CH_ZERO;
                                    job.char_bytes[4] = nib_to_hex(b[7:4]);
                                    job.char_bytes[5] = nib_to_hex(b[3:0]);
                                end
                                else
                                begin
                                    job.char_len      = 3'd1;
                                    job.char_bytes[0] = b;
                                end
                            end
                        endcase
                    end
                    else if (b inside {[LEAD2_LO:LEAD2_HI]})
                    begin
                        held_next[0] = b; held_count_next = 2'd1; seq_len_next = 3'd2;
                    end
                    else if (b inside {[LEAD3_LO:LEAD3_HI]})
                    begin
                        held_next[0] = b; held_count_next = 2'd1; seq_len_next = 3'd3;
                    end
                    else if (b inside {[LEAD4_LO:LEAD4_HI]})
                    begin
                        held_next[0] = b; held_count_next = 2'd1; seq_len_next = 3'd4;
                    end
                    else
                    begin
                        job.rep_a = job.rep_a + 3'd1;
                    end
                end
            end

            if (item.text_end)
            begin
                // flush a truncated sequence and close the text
                job.rep_e       = held_count_next;
                job.close_quote = 1'b1;
                held_count_next = 2'd0;
                seq_len_next    = 3'd0;
                inside_next     = 1'b0;
            end
        end

        total = {5'b0, job.open_quote} + 6'({3'b0, job.rep_a} * 6'd3)
              + {3'b0, job.char_len} + 6'({4'b0, job.rep_e} * 6'd3)
              + {5'b0, job.close_quote};
        job.out_count = (total > 6'(MAX_OUT)) ? 5'(MAX_OUT) : total[4:0];
    end

    assign job_valid = (total != 6'd0);

    // Hold the bytes of an incomplete sequence
    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

    // Advance the sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= 2'd0;
            seq_len_reg    <= 3'd0;
            inside_reg     <= 1'b0;
        end
        else
        begin
            held_count_reg <= held_count_next;
            seq_len_reg    <= seq_len_next;
            inside_reg     <= inside_next;
        end
    end

endmodule

// ===== src/jse_queue.sv =====
// Job queue between the front end and the byte expander.
module jse_queue
    import jse_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  jse_job_t wr_job,
    output logic     full,
    input  logic     rd_en,
    output jse_job_t rd_job,
    output logic     empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jse_job_t          mem_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]     count_reg;
    logic              do_wr, do_rd;

    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_job = mem_reg[rd_ptr_reg];

    // Store a job
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            count_reg <= count_reg + CW'(do_wr) - CW'(do_rd);
        end
    end

endmodule

// ===== src/jse_back.sv =====
// Back end: walks one job and presents its output bytes one at a time.
module jse_back
    import jse_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  jse_job_t job,
    input  logic     job_empty,
    output logic     job_done,
    input  logic     pop,
    output jse_out_t result
);

    logic [3:0] pos_reg, pos_next;
    logic [1:0] rep_reg, rep_next;
    logic [5:0] pos6, a_end, c_end, e_end;
    logic [2:0] q;
    logic       in_rep, last, take;
    logic [7:0] rep_byte;

    assign pos6  = {2'b0, pos_reg};
    assign a_end = {5'b0, job.open_quote} + 6'({3'b0, job.rep_a} * 6'd3);
    assign c_end = a_end + {3'b0, job.char_len};
    assign e_end = c_end + 6'({4'b0, job.rep_e} * 6'd3);
    assign q     = 3'(pos6 - a_end);

    assign in_rep = (pos6 >= {5'b0, job.open_quote} && pos6 < a_end) ||
                    (pos6 >= c_end && pos6 < e_end);
    assign last   = ({1'b0, pos_reg} == job.out_count - 5'd1);
    assign take   = pop && !job_empty;
    assign job_done = take && last;

    // Pick the replacement byte
    always_comb
    begin
        case (rep_reg)
            2'd0:    rep_byte = REP_BYTE0;
            2'd1:    rep_byte = REP_BYTE1;
            default: rep_byte = REP_BYTE2;
        endcase
    end

    // Select the byte at the current position
    always_comb
    begin
        result = '0;
        result.run_last = last;
        if (pos6 < {5'b0, job.open_quote})
        begin
            result.out_byte = CH_QUOTE;
        end
        else if (pos6 < a_end)
        begin
            result.out_byte = rep_byte;
        end
        else if (pos6 < c_end)
        begin
            result.out_byte = job.char_bytes[q];
        end
        else if (pos6 < e_end)
        begin
            result.out_byte = rep_byte;
        end
        else
        begin
            result.out_byte      = CH_QUOTE;
            result.closing_quote = 1'b1;
        end
    end

    // Advance within the job
    always_comb
    begin
        pos_next = pos_reg;
        rep_next = rep_reg;
        if (take)
        begin
            if (last)
            begin
                pos_next = 4'd0;
                rep_next = 2'd0;
            end
            else
            begin
                pos_next = pos_reg + 4'd1;
                rep_next = (in_rep && rep_reg != 2'd2) ? rep_reg + 2'd1 : 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 4'd0;
            rep_reg <= 2'd0;
        end
        else
        begin
            pos_reg <= pos_next;
            rep_reg <= rep_next;
        end
    end

endmodule

// ===== src/jse_checker.sv =====
// Port-level checks for the JSON string escaper, bound to the top level.
module jse_checker
    import jse_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     full,
    input jse_out_t result,
    input logic     empty,
    input logic     pop
);

    // Queue is empty while reset is held
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result queue not empty in reset");

    // A full queue always has a result waiting
    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("queue full and empty at once");

    // Closing quote always ends the item's bytes
    a_close_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.closing_quote) |-> result.run_last)
        else $error("closing quote not marked last");

    // Closing quote carries the quote character
    a_close_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.closing_quote) |-> (result.out_byte == CH_QUOTE))
        else $error("closing quote with wrong byte");

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("stalled result changed");

endmodule

bind json_string_escape_utf8_sanitize jse_checker u_jse_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .full   (full),
    .result (result),
    .empty  (empty),
    .pop    (pop)
);
